[rtl/sbrl_pkg.sv]
// ----------------------------------------------------------------------------
// Serial bank register loader package
// Shared constants, command codes and types for the loader front, queue and
// back end.
// ----------------------------------------------------------------------------
package sbrl_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned SHIFT_W   = 5;
   localparam int unsigned COUNT_W   = 3;
   localparam int unsigned VARIANT_W = 3;

   localparam logic [COUNT_W-1:0] LAST_BIT = 3'd4;

   // command codes
   localparam logic [1:0] CMD_NOP   = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   // register select codes
   localparam logic [1:0] SEL_CONTROL  = 2'd0;
   localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
   localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
   localparam logic [1:0] SEL_PRG      = 2'd3;

   // board variants
   localparam logic [VARIANT_W-1:0] VAR_PLAIN    = 3'd0;
   localparam logic [VARIANT_W-1:0] VAR_RAM_OFF  = 3'd1;
   localparam logic [VARIANT_W-1:0] VAR_RAM_BANK = 3'd2;
   localparam logic [VARIANT_W-1:0] VAR_PAGE     = 3'd3;
   localparam logic [VARIANT_W-1:0] VAR_PAGE_RAM = 3'd4;
   localparam logic [VARIANT_W-1:0] VARIANT_RESET = VAR_PAGE_RAM;

   localparam logic [SHIFT_W-1:0] RESET_SET_MASK = 5'h0c;

   typedef struct packed {
      logic [1:0]         code;
      logic [1:0]         sel;
      logic [SHIFT_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[rtl/sbrl_if.sv]
// ----------------------------------------------------------------------------
// Serial bank register loader channels
// Write request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface sbrl_req_if;
   logic                          valid;
   logic                          ready;
   logic [sbrl_pkg::ADDR_W-1:0]   bus_address;
   logic [sbrl_pkg::DATA_W-1:0]   write_byte;

   modport source(output valid, bus_address, write_byte, input ready);
   modport sink(input valid, bus_address, write_byte, output ready);
endinterface

interface sbrl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           chr_mode_flag;
   logic                           prg_size_flag;
   logic                           prg_mode_flag;
   logic [1:0]                     mirroring;
   logic [sbrl_pkg::SHIFT_W-1:0]   chr_bank_low;
   logic [sbrl_pkg::SHIFT_W-1:0]   chr_bank_high;
   logic [3:0]                     prg_bank_number;
   logic                           ram_off_first;
   logic                           ram_off_second;
   logic [1:0]                     ram_bank_select;
   logic                           prg_page_flag;
   logic                           committed;

   modport source(output valid, chr_mode_flag, prg_size_flag, prg_mode_flag, mirroring,
                  chr_bank_low, chr_bank_high, prg_bank_number, ram_off_first,
                  ram_off_second, ram_bank_select, prg_page_flag, committed,
                  input ready);
   modport sink(input valid, chr_mode_flag, prg_size_flag, prg_mode_flag, mirroring,
                chr_bank_low, chr_bank_high, prg_bank_number, ram_off_first,
                ram_off_second, ram_bank_select, prg_page_flag, committed,
                output ready);
endinterface

interface sbrl_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sbrl_pkg::VARIANT_W-1:0]  board_variant;

   modport source(output valid, board_variant, input ready);
   modport sink(input valid, board_variant, output ready);
endinterface

[rtl/sbrl_front.sv]
// ----------------------------------------------------------------------------
// Serial bank register loader front end
// Accepts bus writes, tracks the serial bit counter and shift value, and
// turns each write into a no-op, reset or register load command.
// ----------------------------------------------------------------------------
module sbrl_front (
   input  logic                   clock,
   input  logic                   reset,
   sbrl_req_if.sink               req_chan,
   input  sbrl_pkg::q_status_type q_status,
   output logic                   push,
   output sbrl_pkg::cmd_type      push_cmd
);

   logic [sbrl_pkg::COUNT_W-1:0] bit_count_ff, bit_count_in;
   logic [sbrl_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [sbrl_pkg::SHIFT_W-1:0] shift_next;

   assign req_chan.ready = !q_status.full && !reset;
   assign push           = req_chan.valid && req_chan.ready;
   assign shift_next     = {req_chan.write_byte[0], shift_ff[sbrl_pkg::SHIFT_W-1:1]};

   always_comb begin
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      push_cmd.code  = sbrl_pkg::CMD_NOP;
      push_cmd.sel   = req_chan.bus_address[14:13];
      push_cmd.value = shift_next;
      if (push && req_chan.bus_address[15]) begin
         if (req_chan.write_byte[7]) begin
            bit_count_in  = '0;
            push_cmd.code = sbrl_pkg::CMD_RESET;
         end else begin
            shift_in = shift_next;
            if (bit_count_ff == sbrl_pkg::LAST_BIT) begin
               bit_count_in  = '0;
               push_cmd.code = sbrl_pkg::CMD_LOAD;
            end else begin
               bit_count_in = bit_count_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= '0;
         shift_ff     <= '0;
      end else begin
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
      end
   end

endmodule

[rtl/sbrl_queue.sv]
// ----------------------------------------------------------------------------
// Serial bank register loader command queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sbrl_queue #(
   parameter int unsigned QUEUE_DEPTH = sbrl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sbrl_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output sbrl_pkg::cmd_type      pop_cmd,
   output sbrl_pkg::q_status_type q_status
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   sbrl_pkg::cmd_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue push while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");

   a_count_track : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not advance on push");

endmodule

[rtl/sbrl_back.sv]
// ----------------------------------------------------------------------------
// Serial bank register loader back end
// Holds the board variant and mapper registers, executes queued commands and
// drives the result word.
// ----------------------------------------------------------------------------
module sbrl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sbrl_pkg::q_status_type q_status,
   input  sbrl_pkg::cmd_type      pop_cmd,
   output logic                   pop,
   sbrl_rsp_if.source             rsp_chan,
   sbrl_csr_if.sink               csr_chan
);

   logic [sbrl_pkg::VARIANT_W-1:0] variant_ff;
   logic [sbrl_pkg::SHIFT_W-1:0]   control_ff, control_in;
   logic [sbrl_pkg::SHIFT_W-1:0]   chr_low_ff, chr_low_in;
   logic [sbrl_pkg::SHIFT_W-1:0]   chr_high_ff, chr_high_in;
   logic [3:0]                     prg_bank_ff, prg_bank_in;
   logic                           ram_off0_ff, ram_off0_in;
   logic                           ram_off1_ff, ram_off1_in;
   logic [1:0]                     ram_bank_ff, ram_bank_in;
   logic                           page_ff, page_in;
   logic                           committed_ff, committed_in;
   logic                           valid_ff, valid_in;
   logic                           chr_load;
   logic [sbrl_pkg::SHIFT_W-1:0]   v;

   assign csr_chan.ready = !reset;
   assign pop      = !q_status.empty && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);
   assign v        = pop_cmd.value;

   always_comb begin
      control_in   = control_ff;
      chr_low_in   = chr_low_ff;
      chr_high_in  = chr_high_ff;
      prg_bank_in  = prg_bank_ff;
      ram_off0_in  = ram_off0_ff;
      ram_off1_in  = ram_off1_ff;
      ram_bank_in  = ram_bank_ff;
      page_in      = page_ff;
      committed_in = committed_ff;
      chr_load     = 1'b0;
      if (pop) begin
         committed_in = 1'b0;
         unique case (pop_cmd.code)
            sbrl_pkg::CMD_RESET: begin
               control_in = control_ff | sbrl_pkg::RESET_SET_MASK;
            end
            sbrl_pkg::CMD_LOAD: begin
               committed_in = 1'b1;
               unique case (pop_cmd.sel)
                  sbrl_pkg::SEL_CONTROL:  control_in = v;
                  sbrl_pkg::SEL_CHR_LOW: begin
                     chr_low_in = v;
                     chr_load   = 1'b1;
                  end
                  sbrl_pkg::SEL_CHR_HIGH: begin
                     chr_high_in = v;
                     chr_load    = 1'b1;
                  end
                  sbrl_pkg::SEL_PRG: begin
                     ram_off0_in = v[4];
                     prg_bank_in = v[3:0];
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      if (chr_load) begin
         unique case (variant_ff)
            sbrl_pkg::VAR_RAM_OFF:  ram_off1_in = v[4];
            sbrl_pkg::VAR_RAM_BANK: ram_bank_in = {1'b0, v[3]};
            sbrl_pkg::VAR_PAGE:     page_in = v[4];
            sbrl_pkg::VAR_PAGE_RAM: begin
               page_in     = v[4];
               ram_bank_in = v[3:2];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= sbrl_pkg::VARIANT_RESET;
         control_ff   <= '0;
         chr_low_ff   <= '0;
         chr_high_ff  <= '0;
         prg_bank_ff  <= '0;
         ram_off0_ff  <= 1'b0;
         ram_off1_ff  <= 1'b0;
         ram_bank_ff  <= '0;
         page_ff      <= 1'b0;
         committed_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            variant_ff <= csr_chan.board_variant;
         end
         control_ff   <= control_in;
         chr_low_ff   <= chr_low_in;
         chr_high_ff  <= chr_high_in;
         prg_bank_ff  <= prg_bank_in;
         ram_off0_ff  <= ram_off0_in;
         ram_off1_ff  <= ram_off1_in;
         ram_bank_ff  <= ram_bank_in;
         page_ff      <= page_in;
         committed_ff <= committed_in;
         valid_ff     <= valid_in;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.chr_mode_flag   = control_ff[4];
   assign rsp_chan.prg_size_flag   = control_ff[3];
   assign rsp_chan.prg_mode_flag   = control_ff[2];
   assign rsp_chan.mirroring       = control_ff[1:0];
   assign rsp_chan.chr_bank_low    = chr_low_ff;
   assign rsp_chan.chr_bank_high   = chr_high_ff;
   assign rsp_chan.prg_bank_number = prg_bank_ff;
   assign rsp_chan.ram_off_first   = ram_off0_ff;
   assign rsp_chan.ram_off_second  = ram_off1_ff;
   assign rsp_chan.ram_bank_select = ram_bank_ff;
   assign rsp_chan.prg_page_flag   = page_ff;
   assign rsp_chan.committed       = committed_ff;

   a_hold_regs : assert property (@(posedge clock) disable iff (reset)
      !pop |=> ($stable(control_ff) && $stable(chr_low_ff) && $stable(chr_high_ff)
                && $stable(prg_bank_ff) && $stable(committed_ff)))
      else $error("registers changed without a command");

   a_reset_sets_mode : assert property (@(posedge clock) disable iff (reset)
      (pop && pop_cmd.code == sbrl_pkg::CMD_RESET) |=>
         (control_ff[3] && control_ff[2] && !committed_ff))
      else $error("reset write did not set program mode bits");

   a_commit_from_load : assert property (@(posedge clock) disable iff (reset)
      (pop && pop_cmd.code != sbrl_pkg::CMD_LOAD) |=> !committed_ff)
      else $error("commit flag without a register load");

endmodule

[rtl/serial_bank_register_loader_unit.sv]
// ----------------------------------------------------------------------------
// Serial bank register loader unit
// Result path: an accepted write goes to a queue entry, then to the result register.
// Throughput: one word per cycle while no result is held unaccepted; the back end
// retires one queued command per cycle. Input ready drops when the command queue is
// full under output stall, and in reset. Reset: synchronous, active high; all mapper
// registers and the bit counter clear, board variant returns to page plus ram-bank.
// ----------------------------------------------------------------------------
module serial_bank_register_loader_unit #(
   parameter int unsigned QUEUE_DEPTH = sbrl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sbrl_req_if.sink    req_chan,
   sbrl_rsp_if.source  rsp_chan,
   sbrl_csr_if.sink    csr_chan
);

   sbrl_pkg::q_status_type q_status;
   sbrl_pkg::cmd_type      push_cmd;
   sbrl_pkg::cmd_type      pop_cmd;
   logic                   push;
   logic                   pop;

   sbrl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   sbrl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   sbrl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_cmd  (pop_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule
